/* sv/ptpd_pkg.sv */
package ptpd_pkg;

    // status codes of a result word
    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_NEG = 2'd1;
    localparam logic [1:0] ST_BIG = 2'd2;

    // field widths
    localparam int SEC_W   = 48;
    localparam int NS_W    = 30;
    localparam int FRAC_W  = 16;
    localparam int DELAY_W = 56;
    localparam int LIMIT_W = 10;

    // whole-second difference, its clamp and nanosecond arithmetic
    localparam int DS_W    = SEC_W + 1;
    localparam int DNS_W   = NS_W + 1;
    localparam int DFRAC_W = FRAC_W + 1;
    localparam int PROD_W  = 42;
    localparam int TOTAL_W = 44;
    localparam int THR_W   = 41;
    localparam int NSINT_W = DELAY_W - FRAC_W;

    localparam logic signed [DS_W-1:0] SEC_CLAMP_POS = 49'sd2048;
    localparam logic signed [DS_W-1:0] SEC_CLAMP_NEG = -49'sd2048;

    localparam logic signed [PROD_W-1:0] NS_PER_SEC_S = 42'sd1000000000;
    localparam logic [THR_W-1:0] NS_PER_SEC_U = 41'd1000000000;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd1000;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_CHECK,
        S_READ,
        S_DONE
    } t_state;

    // stage strobes for the difference datapath
    typedef struct packed {
        logic load;
        logic mul;
        logic sum;
    } t_check_ctl;

endpackage

/* sv/ptpd_ring.sv */
module ptpd_ring #(
    parameter int DEPTH = 5,
    parameter int AW    = 3
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr_en,
    input  logic [AW-1:0]                i_wr_addr,
    input  logic [ptpd_pkg::DELAY_W-1:0] i_wr_data,
    input  logic                         i_rd_en,
    input  logic [AW-1:0]                i_rd_addr,
    output logic [ptpd_pkg::DELAY_W-1:0] o_rd_data
);
    import ptpd_pkg::*;

    logic [DELAY_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]   r_valid;
    logic [DELAY_W-1:0] r_rd_data;
    logic               r_rd_valid;

    // delay storage, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // per-entry valid bits, an unwritten entry reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

/* sv/ptpd_check.sv */
module ptpd_check (
    input  logic                         i_clk,
    input  ptpd_pkg::t_check_ctl         i_ctl,
    input  logic [ptpd_pkg::LIMIT_W-1:0] i_limit,
    input  logic [ptpd_pkg::SEC_W-1:0]   i_slave_seconds,
    input  logic [ptpd_pkg::NS_W-1:0]    i_slave_nanoseconds,
    input  logic [ptpd_pkg::FRAC_W-1:0]  i_slave_frac_ns,
    input  logic [ptpd_pkg::SEC_W-1:0]   i_master_seconds,
    input  logic [ptpd_pkg::NS_W-1:0]    i_master_nanoseconds,
    input  logic [ptpd_pkg::FRAC_W-1:0]  i_master_frac_ns,
    output logic [1:0]                   o_status,
    output logic [ptpd_pkg::DELAY_W-1:0] o_delay
);
    import ptpd_pkg::*;

    logic signed [DS_W-1:0]    r_ds;
    logic signed [DNS_W-1:0]   r_dns;
    logic signed [DFRAC_W-1:0] r_dfrac;
    logic [1:0]                r_clamp;
    logic signed [PROD_W-1:0]  r_prod;
    logic [THR_W-1:0]          r_thr;
    logic signed [TOTAL_W-1:0] r_total;
    logic signed [TOTAL_W-1:0] ns_int;

    // field differences of the captured word
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_ds    <= $signed({1'b0, i_master_seconds}) - $signed({1'b0, i_slave_seconds});
            r_dns   <= $signed({1'b0, i_master_nanoseconds})
                     - $signed({1'b0, i_slave_nanoseconds});
            r_dfrac <= $signed({1'b0, i_master_frac_ns}) - $signed({1'b0, i_slave_frac_ns});
        end
    end

    // seconds clamp, seconds to nanoseconds, limit threshold
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            if (r_ds >= SEC_CLAMP_POS) begin
                r_clamp <= ST_BIG;
            end else if (r_ds <= SEC_CLAMP_NEG) begin
                r_clamp <= ST_NEG;
            end else begin
                r_clamp <= ST_OK;
            end
            r_prod <= $signed(r_ds[11:0]) * NS_PER_SEC_S;
            r_thr  <= (THR_W'(i_limit) + THR_W'(1)) * NS_PER_SEC_U;
        end
    end

    // whole nanosecond difference
    always_ff @(posedge i_clk) begin
        if (i_ctl.sum) begin
            r_total <= TOTAL_W'(r_prod) + TOTAL_W'(r_dns);
        end
    end

    // a negative fraction borrows one nanosecond
    assign ns_int = r_total - TOTAL_W'(r_dfrac[DFRAC_W-1]);

    // classify against sign and seconds limit
    always_comb begin
        if (r_clamp != ST_OK) begin
            o_status = r_clamp;
        end else if (ns_int[TOTAL_W-1]) begin
            o_status = ST_NEG;
        end else if (ns_int >= $signed({3'b000, r_thr})) begin
            o_status = ST_BIG;
        end else begin
            o_status = ST_OK;
        end
    end

    assign o_delay = {ns_int[NSINT_W-1:0], r_dfrac[FRAC_W-1:0]};

endmodule

/* sv/ptp_path_delay_average_filter_core.sv */
// channel | direction | handshake                 | payload
// input   | in        | i_valid / o_stall         | i_slave_*, i_master_* timestamps
// output  | out       | o_valid / i_stall         | o_mean_path_delay, o_status
// config  | in        | i_cfg_wr_en               | i_cfg_wr_data (seconds limit)
//
// a word is taken in S_IDLE and passes S_MUL, S_SUM and S_CHECK; a rejected word goes on to
// S_DONE, an accepted word is written and first read back over all RING_DEPTH entries of the
// one-port ring memory in S_READ; the input opens again when S_DONE hands on the result
// one word is in work at a time; the output register lets the next word in
// while a result still waits under i_stall
// reset is synchronous, active low; per-entry valid bits clear the ring at once
module ptp_path_delay_average_filter_core #(
    parameter int RING_DEPTH = 5
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [ptpd_pkg::LIMIT_W-1:0] i_cfg_wr_data,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [ptpd_pkg::SEC_W-1:0]   i_slave_seconds,
    input  logic [ptpd_pkg::NS_W-1:0]    i_slave_nanoseconds,
    input  logic [ptpd_pkg::FRAC_W-1:0]  i_slave_frac_ns,
    input  logic [ptpd_pkg::SEC_W-1:0]   i_master_seconds,
    input  logic [ptpd_pkg::NS_W-1:0]    i_master_nanoseconds,
    input  logic [ptpd_pkg::FRAC_W-1:0]  i_master_frac_ns,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [ptpd_pkg::DELAY_W-1:0] o_mean_path_delay,
    output logic [1:0]                   o_status
);
    import ptpd_pkg::*;

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(RING_DEPTH - 1);
    localparam logic [CW-1:0] CNT_END   = CW'(RING_DEPTH);

    t_state             r_state, n_state;
    t_check_ctl         ctl;
    logic [LIMIT_W-1:0] r_limit;
    logic [AW-1:0]      r_ptr;
    logic [AW-1:0]      r_rd_addr;
    logic [CW-1:0]      r_cnt;
    logic [DELAY_W-1:0] r_acc;
    logic [DELAY_W-1:0] r_mean;
    logic [1:0]         r_status;
    logic               r_out_valid;
    logic [DELAY_W-1:0] r_out_mean;
    logic [1:0]         r_out_status;

    logic [1:0]         chk_status;
    logic [DELAY_W-1:0] chk_delay;
    logic               ring_wr_en;
    logic               ring_rd_en;
    logic [DELAY_W-1:0] ring_rd_data;
    logic [DELAY_W-1:0] avg_next;
    logic               in_take;
    logic               out_free;
    logic [AW-1:0]      ptr_next;

    assign in_take  = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;
    assign ptr_next = (r_ptr == LAST_ADDR) ? '0 : r_ptr + AW'(1);

    // seconds limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            r_limit <= i_cfg_wr_data;
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and stage strobes
    always_comb begin
        n_state    = r_state;
        ctl        = '0;
        ring_wr_en = 1'b0;
        ring_rd_en = 1'b0;
        o_stall    = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_stall  = 1'b0;
                ctl.load = i_valid;
                if (i_valid) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                ctl.mul = 1'b1;
                n_state = S_SUM;
            end
            S_SUM: begin
                ctl.sum = 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (chk_status == ST_OK) begin
                    ring_wr_en = 1'b1;
                    n_state    = S_READ;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                ring_rd_en = (r_cnt < CNT_END);
                if (r_cnt == CNT_END) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // write pointer and read walk over the ring
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
            r_cnt <= '0;
        end else if (ring_wr_en) begin
            r_ptr <= ptr_next;
            r_cnt <= '0;
        end else if (r_state == S_READ) begin
            r_cnt <= r_cnt + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ring_wr_en) begin
            r_rd_addr <= ptr_next;
        end else if (ring_rd_en) begin
            r_rd_addr <= (r_rd_addr == LAST_ADDR) ? '0 : r_rd_addr + AW'(1);
        end
    end

    // cascaded halving, oldest entry first
    assign avg_next = DELAY_W'(({1'b0, r_acc} + {1'b0, ring_rd_data}) >> 1);

    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            if (r_cnt == CW'(1)) begin
                r_acc <= ring_rd_data;
            end else begin
                r_acc <= avg_next;
            end
        end
    end

    // mean and status of the word in work
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean <= '0;
        end else if (r_state == S_READ && r_cnt == CNT_END) begin
            r_mean <= avg_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CHECK) begin
            r_status <= chk_status;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out_mean   <= r_mean;
            r_out_status <= r_status;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_mean_path_delay = r_out_mean;
    assign o_status          = r_out_status;

    ptpd_check u_check (
        .i_clk               (i_clk),
        .i_ctl               (ctl),
        .i_limit             (r_limit),
        .i_slave_seconds     (i_slave_seconds),
        .i_slave_nanoseconds (i_slave_nanoseconds),
        .i_slave_frac_ns     (i_slave_frac_ns),
        .i_master_seconds    (i_master_seconds),
        .i_master_nanoseconds(i_master_nanoseconds),
        .i_master_frac_ns    (i_master_frac_ns),
        .o_status            (chk_status),
        .o_delay             (chk_delay)
    );

    ptpd_ring #(
        .DEPTH(RING_DEPTH),
        .AW   (AW)
    ) u_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (ring_wr_en),
        .i_wr_addr(r_ptr),
        .i_wr_data(chk_delay),
        .i_rd_en  (ring_rd_en),
        .i_rd_addr(r_rd_addr),
        .o_rd_data(ring_rd_data)
    );

`ifndef SYNTHESIS
    a_take_then_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> o_stall)
        else $error("input taken but block not busy next cycle");

    a_no_wr_rd_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ring_wr_en |-> !ring_rd_en)
        else $error("ring write and read in the same cycle");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_cnt <= CNT_END))
        else $error("ring walk past depth");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_NEG || o_status == ST_BIG))
        else $error("undefined status code on output");
`endif

endmodule

/* tb/sv/ptp_path_delay_average_filter_core_test.sv */
`timescale 1ns / 1ps

module ptp_path_delay_average_filter_core_test;

    import ptpd_pkg::*;

    localparam int HIST_DEPTH = 5;
    localparam int CYCLE_LIMIT = 600000;
    localparam int IDLE_SETTLE = 15;
    localparam int LONG_HOLD = 300;
    localparam int PHASE_WORDS = 144;
    localparam logic [SEC_W-1:0] MAX_SEC = {SEC_W{1'b1}};
    localparam logic [NS_W-1:0] MAX_NS = {NS_W{1'b1}};
    localparam logic [FRAC_W-1:0] MAX_FRAC = {FRAC_W{1'b1}};
    localparam logic signed [63:0] NS_PER_S = 64'sd1000000000;

    // one timestamp pair as offered on the input channel
    typedef struct packed {
        logic [SEC_W-1:0]  s_sec;
        logic [NS_W-1:0]   s_ns;
        logic [FRAC_W-1:0] s_frac;
        logic [SEC_W-1:0]  m_sec;
        logic [NS_W-1:0]   m_ns;
        logic [FRAC_W-1:0] m_frac;
    } t_stamp;

    typedef struct packed {
        logic [DELAY_W-1:0] mean;
        logic [1:0]         status;
    } t_result;

    typedef struct {
        int      lim;
        t_stamp  w;
        bit      typed;
        t_result want;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic [LIMIT_W-1:0]   i_cfg_wr_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [SEC_W-1:0]     i_slave_seconds = '0;
    logic [NS_W-1:0]      i_slave_nanoseconds = '0;
    logic [FRAC_W-1:0]    i_slave_frac_ns = '0;
    logic [SEC_W-1:0]     i_master_seconds = '0;
    logic [NS_W-1:0]      i_master_nanoseconds = '0;
    logic [FRAC_W-1:0]    i_master_frac_ns = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [DELAY_W-1:0]   o_mean_path_delay;
    logic [1:0]           o_status;

    // predictor state: delay history, write slot, mean and seconds limit
    logic [DELAY_W-1:0] delay_hist [HIST_DEPTH];
    int                 hist_wr_ptr = 0;
    logic [DELAY_W-1:0] mean_now = '0;
    int                 limit_sec = int'(LIMIT_RESET);

    t_result pending_means [$];
    t_row    dir_tab [$];
    int      err_cnt = 0;
    int      cycles = 0;
    bit      quiet = 1'b0;
    bit      hold_req = 1'b0;
    int      hold_left = 0;
    int      stall_left = 0;
    int      lim_seq [8];

    ptp_path_delay_average_filter_core #(
        .RING_DEPTH(HIST_DEPTH)
    ) DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_wr_data       (i_cfg_wr_data),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_slave_seconds     (i_slave_seconds),
        .i_slave_nanoseconds (i_slave_nanoseconds),
        .i_slave_frac_ns     (i_slave_frac_ns),
        .i_master_seconds    (i_master_seconds),
        .i_master_nanoseconds(i_master_nanoseconds),
        .i_master_frac_ns    (i_master_frac_ns),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_mean_path_delay   (o_mean_path_delay),
        .o_status            (o_status)
    );

    always #5 i_clk = ~i_clk;

    // mean delay and status after one offered word, updating the history if it is accepted
    function automatic t_result predict_mean_delay(t_stamp w);
        logic signed [63:0] dsec;
        logic signed [63:0] tot_ns;
        logic signed [63:0] scaled;
        logic [63:0]        whole_s;
        logic [63:0]        acc;
        int                 idx;
        t_result            r;
        dsec = $signed({16'd0, w.m_sec}) - $signed({16'd0, w.s_sec});
        r.status = ST_OK;
        if (dsec >= SEC_CLAMP_POS) begin
            r.status = ST_BIG;
        end else if (dsec <= SEC_CLAMP_NEG) begin
            r.status = ST_NEG;
        end else begin
            tot_ns = dsec * NS_PER_S + ($signed({34'd0, w.m_ns}) - $signed({34'd0, w.s_ns}));
            scaled = tot_ns * 64'sd65536
                   + ($signed({48'd0, w.m_frac}) - $signed({48'd0, w.s_frac}));
            if (scaled < 0) begin
                r.status = ST_NEG;
            end else begin
                whole_s = scaled;
                whole_s = (whole_s >> FRAC_W) / 64'd1000000000;
                if (whole_s > limit_sec) begin
                    r.status = ST_BIG;
                end else begin
                    delay_hist[hist_wr_ptr] = scaled[DELAY_W-1:0];
                    hist_wr_ptr = (hist_wr_ptr + 1) % HIST_DEPTH;
                    // halving cascade, oldest entry first
                    idx = hist_wr_ptr;
                    acc = ({8'd0, delay_hist[idx]}
                        + {8'd0, delay_hist[(idx + 1) % HIST_DEPTH]}) >> 1;
                    for (int j = 2; j < HIST_DEPTH; j++) begin
                        acc = (acc + {8'd0, delay_hist[(idx + j) % HIST_DEPTH]}) >> 1;
                    end
                    mean_now = acc[DELAY_W-1:0];
                end
            end
        end
        r.mean = mean_now;
        return r;
    endfunction

    function automatic t_row mk_row(int lim, logic [SEC_W-1:0] ss, logic [NS_W-1:0] sns,
                                    logic [FRAC_W-1:0] sf, logic [SEC_W-1:0] ms,
                                    logic [NS_W-1:0] mns, logic [FRAC_W-1:0] mf,
                                    bit typed, logic [DELAY_W-1:0] mean, logic [1:0] st);
        t_row r;
        r.lim = lim;
        r.w = '{s_sec: ss, s_ns: sns, s_frac: sf, m_sec: ms, m_ns: mns, m_frac: mf};
        r.typed = typed;
        r.want = '{mean: mean, status: st};
        return r;
    endfunction

    // random timestamp pair, mostly plausible delays around the limit
    function automatic t_stamp rand_stamp(int lim);
        t_stamp           w;
        int               k;
        int               ds;
        int               mns;
        logic [SEC_W-1:0] base;
        k = int'($urandom_range(99));
        ds = 0;
        base[47:32] = 16'($urandom);
        base[31:0] = $urandom;
        if (base < 4096) begin
            base = base + 4096;
        end else if (base > MAX_SEC - 4096) begin
            base = base - 4096;
        end
        w.s_sec = base;
        w.s_ns = NS_W'($urandom_range(999999999));
        w.m_ns = NS_W'($urandom_range(999999999));
        w.s_frac = 16'($urandom);
        w.m_frac = 16'($urandom);
        if (k < 45) begin
            ds = ($urandom_range(3) == 0) ? 1 : 0;
            if (ds == 0) begin
                mns = int'(w.s_ns) + int'($urandom_range(2000000)) - 100000;
                if (mns < 0) begin
                    mns = 0;
                end
                w.m_ns = NS_W'(mns);
            end
        end else if (k < 70) begin
            ds = int'($urandom_range(lim + 1));
        end else if (k < 82) begin
            ds = lim - 1 + int'($urandom_range(2));
        end else if (k < 88) begin
            ds = -int'($urandom_range(3));
        end else if (k >= 94) begin
            // noise: nanoseconds over their range
            ds = int'($urandom_range(4)) - 2;
            w.s_ns = NS_W'($urandom);
            w.m_ns = NS_W'($urandom);
        end
        w.m_sec = base + SEC_W'(ds);
        if (k >= 88 && k < 94) begin
            w.m_sec[47:32] = 16'($urandom);
            w.m_sec[31:0] = $urandom;
        end
        return w;
    endfunction

    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(99));
        if (quiet || r < 65) begin
            return 0;
        end else if (r < 93) begin
            return int'($urandom_range(3, 1));
        end
        return int'($urandom_range(40, 10));
    endfunction

    task automatic idle_cycles(int n);
        if (n > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // offer one word, then log its expected result
    task automatic deliver(t_stamp w, bit typed, t_result want);
        t_result got;
        @(negedge i_clk);
        i_slave_seconds <= w.s_sec;
        i_slave_nanoseconds <= w.s_ns;
        i_slave_frac_ns <= w.s_frac;
        i_master_seconds <= w.m_sec;
        i_master_nanoseconds <= w.m_ns;
        i_master_frac_ns <= w.m_frac;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        got = predict_mean_delay(w);
        pending_means.push_back(typed ? want : got);
        idle_cycles(pick_gap());
    endtask

    // wait for every result, let the block settle, then set the limit
    task automatic drain_then_config(int lim);
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_means.size() != 0) @(posedge i_clk);
        repeat (IDLE_SETTLE) @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= LIMIT_W'(lim);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        limit_sec = lim;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_means.size() == 0) begin
                $display("%0t unexpected word: mean %0d status %0d",
                         $realtime, o_mean_path_delay, o_status);
                err_cnt++;
            end else begin
                e = pending_means.pop_front();
                if (o_mean_path_delay !== e.mean) begin
                    $display("%0t mean mismatch: expected %0d actual %0d",
                             $realtime, e.mean, o_mean_path_delay);
                    err_cnt++;
                end
                if (o_status !== e.status) begin
                    $display("%0t status mismatch: expected %0d actual %0d",
                             $realtime, e.status, o_status);
                    err_cnt++;
                end
            end
        end
    end

    // receiver stall, with an occasional long hold
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = LONG_HOLD;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (quiet || $urandom_range(99) < 65) begin
                i_stall <= 1'b0;
            end else if ($urandom_range(99) < 85) begin
                stall_left = int'($urandom_range(2));
                i_stall <= 1'b1;
            end else begin
                stall_left = int'($urandom_range(39, 9));
                i_stall <= 1'b1;
            end
        end
    end

    // timeout
    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

    // stimulus
    initial begin
        for (int i = 0; i < HIST_DEPTH; i++) begin
            delay_hist[i] = '0;
        end
        // equal stamps, extremes and sign boundaries straight after reset
        dir_tab.push_back(mk_row(1000, 100, 5, 7, 100, 5, 7, 1, 0, ST_OK));
        dir_tab.push_back(mk_row(1000, MAX_SEC, 0, 0, 0, 0, 0, 1, 0, ST_NEG));
        dir_tab.push_back(mk_row(1000, 0, 0, 0, MAX_SEC, MAX_NS, MAX_FRAC, 1, 0, ST_BIG));
        dir_tab.push_back(mk_row(1000, 2048, 0, 0, 0, 0, 0, 1, 0, ST_NEG));
        dir_tab.push_back(mk_row(1000, 0, 0, 0, 2048, 0, 0, 1, 0, ST_BIG));
        dir_tab.push_back(mk_row(1000, 10, 1, 0, 10, 0, 0, 1, 0, ST_NEG));
        dir_tab.push_back(mk_row(1000, 10, 0, 1, 10, 0, 0, 1, 0, ST_NEG));
        // accepted delays filling the history, limit edges
        dir_tab.push_back(mk_row(1000, 0, 0, 0, 0, 0, 1, 0, 0, ST_OK));
        dir_tab.push_back(mk_row(1000, 5, 0, 0, 1005, 0, 0, 0, 0, ST_OK));
        dir_tab.push_back(mk_row(1000, 5, 0, 0, 1005, 999999999, MAX_FRAC, 0, 0, ST_OK));
        dir_tab.push_back(mk_row(1000, 5, 0, 0, 1006, 0, 0, 0, 0, ST_OK));
        // nanoseconds over range taken at face value, seconds just inside the clamp
        dir_tab.push_back(mk_row(1000, 0, MAX_NS, 0, 1, 0, 0, 0, 0, ST_OK));
        dir_tab.push_back(mk_row(1000, 0, MAX_NS, 0, 2, 0, 0, 0, 0, ST_OK));
        dir_tab.push_back(mk_row(1000, 3000, 0, 0, 5047, 0, 0, 0, 0, ST_OK));
        dir_tab.push_back(mk_row(1000, 5047, 0, 0, 3000, 0, 0, 0, 0, ST_OK));
        // limit above the reset value
        dir_tab.push_back(mk_row(1023, 0, 0, 0, 1023, 999999999, MAX_FRAC, 0, 0, ST_OK));
        dir_tab.push_back(mk_row(1023, 0, 0, 0, 1024, 0, 0, 0, 0, ST_OK));
        dir_tab.push_back(mk_row(1023, MAX_SEC - 1, 0, 0, MAX_SEC, MAX_NS, MAX_FRAC,
                                 0, 0, ST_OK));
        // zero limit
        dir_tab.push_back(mk_row(0, 7, 0, 0, 7, 999999999, MAX_FRAC, 0, 0, ST_OK));
        dir_tab.push_back(mk_row(0, 7, 0, 0, 8, 0, 0, 0, 0, ST_OK));
        dir_tab.push_back(mk_row(0, 7, MAX_NS, 0, 8, 0, 0, 0, 0, ST_OK));

        lim_seq[0] = 1000;
        lim_seq[1] = 1;
        lim_seq[2] = 1023;
        lim_seq[3] = int'($urandom_range(1023));
        lim_seq[4] = 0;
        lim_seq[5] = int'($urandom_range(1023));
        lim_seq[6] = 2;
        lim_seq[7] = 1000;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        foreach (dir_tab[i]) begin
            if (dir_tab[i].lim != limit_sec) begin
                drain_then_config(dir_tab[i].lim);
            end
            deliver(dir_tab[i].w, dir_tab[i].typed, dir_tab[i].want);
        end

        // random phases, one limit each
        for (int p = 0; p < 8; p++) begin
            drain_then_config(lim_seq[p]);
            quiet = (p == 2 || p == 5);
            for (int i = 0; i < PHASE_WORDS; i++) begin
                if (p == 2 && i == 10) begin
                    hold_req = 1'b1;
                end
                deliver(rand_stamp(limit_sec), 1'b0, '0);
            end
        end
        quiet = 1'b0;

        // drain and report
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_means.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
